FILE: hdl/mdis_pkg.sv
// ----------------------------------------------------------------------------
// mdis_pkg
// Shared constants and types for the magnitude-descending insertion sorter.
// ----------------------------------------------------------------------------
package mdis_pkg;

    localparam int MAX_ELEMS  = 64;
    localparam int DATA_WIDTH = 16;
    localparam int CNT_W      = $clog2(MAX_ELEMS + 1);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic                         last;
    } t_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] sorted_value;
        logic                         final_res;
        logic                         dropped;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_one;
    } t_sts;

    function automatic logic [DATA_WIDTH:0] magnitude(input logic [DATA_WIDTH-1:0] v);
        logic [DATA_WIDTH:0] ext;
        ext = {v[DATA_WIDTH-1], v};
        return v[DATA_WIDTH-1] ? (~ext + 1'b1) : ext;
    endfunction

endpackage

FILE: hdl/mdis_ctrl.sv
// ----------------------------------------------------------------------------
// mdis_ctrl
// Controller: collects a list, then streams the sorted list out.
// ----------------------------------------------------------------------------
module mdis_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  mdis_pkg::t_sts  i_sts,
    output mdis_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.insert = 1'b0;
        o_cmd.pop    = 1'b0;
        unique case (r_state)
            ST_COLLECT: begin
                o_cmd.insert = i_valid;
                if (i_valid && i_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.pop = !i_stall;
                if (!i_stall && i_sts.last_one) begin
                    n_state = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    assign o_stall = (r_state != ST_COLLECT);
    assign o_valid = (r_state == ST_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/mdis_datapath.sv
// ----------------------------------------------------------------------------
// mdis_datapath
// Row of sorted cells with parallel compare-and-shift insert and pop to front.
// ----------------------------------------------------------------------------
module mdis_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mdis_pkg::t_cmd                    i_cmd,
    input  logic [mdis_pkg::DATA_WIDTH-1:0]   i_value,
    output mdis_pkg::t_sts                    o_sts,
    output mdis_pkg::t_out                    o_data
);

    logic [mdis_pkg::DATA_WIDTH-1:0] r_cell [mdis_pkg::MAX_ELEMS];
    logic [mdis_pkg::DATA_WIDTH-1:0] n_cell [mdis_pkg::MAX_ELEMS];
    logic [mdis_pkg::CNT_W-1:0]      r_count;
    logic [mdis_pkg::CNT_W-1:0]      n_count;
    logic                            r_ovf;
    logic                            n_ovf;

    logic [mdis_pkg::MAX_ELEMS-1:0]  stay;
    logic [mdis_pkg::DATA_WIDTH:0]   new_mag;
    logic                            full;

    assign new_mag = mdis_pkg::magnitude(i_value);
    assign full    = (r_count == mdis_pkg::CNT_W'(mdis_pkg::MAX_ELEMS));

    // a cell keeps its entry when it holds an equal or larger magnitude
    always_comb begin
        for (int i = 0; i < mdis_pkg::MAX_ELEMS; i++) begin
            stay[i] = (mdis_pkg::CNT_W'(i) < r_count)
                      && (mdis_pkg::magnitude(r_cell[i]) >= new_mag);
        end
    end

    always_comb begin
        n_cell  = r_cell;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_cmd.insert) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
                if (!stay[0]) begin
                    n_cell[0] = i_value;
                end
                for (int i = 1; i < mdis_pkg::MAX_ELEMS; i++) begin
                    if (!stay[i]) begin
                        n_cell[i] = stay[i-1] ? i_value : r_cell[i-1];
                    end
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < mdis_pkg::MAX_ELEMS - 1; i++) begin
                n_cell[i] = r_cell[i+1];
            end
            n_count = r_count - 1'b1;
            if (o_sts.last_one) begin
                n_ovf = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    assign o_sts.last_one     = (r_count == mdis_pkg::CNT_W'(1));
    assign o_data.sorted_value = r_cell[0];
    assign o_data.final_res    = o_sts.last_one;
    assign o_data.dropped      = r_ovf;

endmodule

FILE: hdl/magnitude_descending_insertion_sorter_top.sv
// ----------------------------------------------------------------------------
// magnitude_descending_insertion_sorter_top
// Sorts a list by descending absolute value, stable, and streams it out.
// ----------------------------------------------------------------------------
// throughput: one input beat per cycle while a list is collected (parallel
//   insert across the cell row)
// output: first sorted beat in the cycle after the last input beat; the list
//   then streams out one beat per cycle while i_stall is low, and input
//   stalls until the final beat is taken
// reset: synchronous active low, store empties at once, no clearing pass
// ----------------------------------------------------------------------------
module magnitude_descending_insertion_sorter_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mdis_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output mdis_pkg::t_out o_data
);

    mdis_pkg::t_cmd cmd;
    mdis_pkg::t_sts sts;

    mdis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_data.last),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    mdis_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_value (i_data.value),
        .o_sts   (sts),
        .o_data  (o_data)
    );

endmodule
